// ===== rtl/srarq_pkg.sv =====
// ----------------------------------------------------------------------------
// srarq_pkg
// Shared types, codes and sequence helpers for the selective-repeat ARQ
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package srarq_pkg;

    // Sequence space and window.
    localparam int SEQ_W     = 7;
    localparam int SLOT_W    = 6;
    localparam int NR_SLOTS  = 64;
    localparam int DUR_W     = 16;
    localparam int MASK_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 4;

    // Reset values of the configuration registers.
    localparam logic [DUR_W-1:0] DATA_TIMEOUT_RST = 16'd8000;
    localparam logic [DUR_W-1:0] ACK_DELAY_RST    = 16'd260;
    localparam logic [DUR_W-1:0] BACKOFF_RST      = 16'd100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF      = 2'd2;

    // Event codes.
    localparam logic [2:0] FN_NET_READY = 3'd0;
    localparam logic [2:0] FN_PHY_READY = 3'd1;
    localparam logic [2:0] FN_FRAME_RX  = 3'd2;
    localparam logic [2:0] FN_DATA_TO   = 3'd3;
    localparam logic [2:0] FN_ACK_TO    = 3'd4;

    // Received frame kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;
    localparam logic [1:0] KIND_HACK = 2'd3;

    // Action codes of a result.
    localparam logic [3:0] ACT_SEND_DATA = 4'd0;
    localparam logic [3:0] ACT_SEND_ACK  = 4'd1;
    localparam logic [3:0] ACT_SEND_NAK  = 4'd2;
    localparam logic [3:0] ACT_START_DT  = 4'd3;
    localparam logic [3:0] ACT_STOP_DT   = 4'd4;
    localparam logic [3:0] ACT_START_AT  = 4'd5;
    localparam logic [3:0] ACT_STOP_AT   = 4'd6;
    localparam logic [3:0] ACT_DELIVER   = 4'd7;
    localparam logic [3:0] ACT_STATUS    = 4'd8;

    // Result forms the datapath can build.
    typedef enum logic [3:0] {
        RES_SEND_DATA,
        RES_START_DT,
        RES_BACKOFF_DT,
        RES_NAK,
        RES_STOP_ACK,
        RES_START_ACK,
        RES_DELIVER,
        RES_HMASK,
        RES_STOP_DT,
        RES_SEND_ACK,
        RES_STATUS
    } res_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SEND,
        S_START_DT,
        S_NAK,
        S_STOP_ACK,
        S_START_ACK,
        S_TD_CHK,
        S_TD_ROT,
        S_TD_RUN,
        S_TD_CLR,
        S_DELIVER,
        S_HMASK,
        S_ACKCALC,
        S_ACKUPD,
        S_STOPDT,
        S_BACKOFF,
        S_SACK,
        S_STATUS
    } state_t;

    typedef struct packed {
        logic load;
        logic emit_en;
        res_t res;
        logic set_phy;
        logic arrive_set;
        logic rot_en;
        logic run_en;
        logic clr_en;
        logic ack_calc;
        logic ack_upd;
    } cmd_t;

    typedef struct packed {
        logic       out_free;
        logic [2:0] func;
        logic [1:0] kind;
        logic       ok;
        logic       can_send;
        logic       miss_in;
        logic       retx_ok;
        logic       nak_cond;
        logic       td_drop;
        logic       hmask_nz;
        logic       cnt_nz;
    } stat_t;

    // True when b lies in the circular range [a, c).
    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/srarq_ctrl.sv =====
// ----------------------------------------------------------------------------
// srarq_ctrl
// Sequencer that walks one event through its result and update steps.
// ----------------------------------------------------------------------------
`default_nettype none

module srarq_ctrl
    import srarq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // State and return-point registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_STATUS;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.res    = RES_STATUS;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ret_next   = S_STATUS;
                state_next = S_STATUS;
                case (stat.func)
                    FN_NET_READY: state_next = stat.can_send ? S_SEND : S_STATUS;
                    FN_PHY_READY: cmd.set_phy = 1'b1;
                    FN_FRAME_RX:
                    begin
                        if (!stat.ok)
                            state_next = S_NAK;
                        else
                        begin
                            case (stat.kind)
                                KIND_NAK:  state_next = stat.miss_in ? S_SEND : S_STATUS;
                                KIND_DATA:
                                begin
                                    ret_next   = S_TD_CHK;
                                    state_next = stat.nak_cond ? S_NAK : S_START_ACK;
                                end
                                KIND_HACK: state_next = stat.hmask_nz ? S_HMASK : S_ACKCALC;
                                default:   state_next = S_ACKCALC;
                            endcase
                        end
                    end
                    FN_DATA_TO: state_next = stat.retx_ok ? S_SEND : S_BACKOFF;
                    FN_ACK_TO:  state_next = S_SACK;
                    default:    state_next = S_STATUS;
                endcase
            end
            S_SEND:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_SEND_DATA;
                    state_next  = S_START_DT;
                end
            end
            S_START_DT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_START_DT;
                    ret_next    = S_STATUS;
                    state_next  = S_STOP_ACK;
                end
            end
            S_NAK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_NAK;
                    state_next  = S_STOP_ACK;
                end
            end
            S_STOP_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_STOP_ACK;
                    state_next  = ret_reg;
                end
            end
            S_START_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_START_ACK;
                    state_next  = ret_reg;
                end
            end
            S_TD_CHK:
            begin
                if (stat.td_drop)
                begin
                    ret_next   = S_ACKCALC;
                    state_next = S_START_ACK;
                end
                else
                begin
                    cmd.arrive_set = 1'b1;
                    state_next     = S_TD_ROT;
                end
            end
            S_TD_ROT:
            begin
                cmd.rot_en = 1'b1;
                state_next = S_TD_RUN;
            end
            S_TD_RUN:
            begin
                cmd.run_en = 1'b1;
                state_next = S_TD_CLR;
            end
            S_TD_CLR:
            begin
                cmd.clr_en = 1'b1;
                state_next = stat.cnt_nz ? S_DELIVER : S_ACKCALC;
            end
            S_DELIVER:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_DELIVER;
                    ret_next    = S_ACKCALC;
                    state_next  = S_START_ACK;
                end
            end
            S_HMASK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_HMASK;
                    state_next  = S_ACKCALC;
                end
            end
            S_ACKCALC:
            begin
                cmd.ack_calc = 1'b1;
                state_next   = S_ACKUPD;
            end
            S_ACKUPD:
            begin
                cmd.ack_upd = 1'b1;
                state_next  = stat.cnt_nz ? S_STOPDT : S_STATUS;
            end
            S_STOPDT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_STOP_DT;
                    state_next  = S_STATUS;
                end
            end
            S_BACKOFF:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_BACKOFF_DT;
                    state_next  = S_STATUS;
                end
            end
            S_SACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_SEND_ACK;
                    state_next  = S_STOP_ACK;
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    cmd.res     = RES_STATUS;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/srarq_dp.sv =====
// ----------------------------------------------------------------------------
// srarq_dp
// Link state, window bit vectors, run and ack arithmetic, and the result
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srarq_dp
    import srarq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [DUR_W-1:0]     cfg_data,
    input  wire logic [2:0]           func,
    input  wire logic [1:0]           frame_kind,
    input  wire logic                 frame_ok,
    input  wire logic [SEQ_W-1:0]     frame_seq,
    input  wire logic [SEQ_W-1:0]     peer_ack,
    input  wire logic [MASK_W-1:0]    half_ack_mask,
    input  wire logic [SLOT_W-1:0]    timer_slot,
    input  wire cmd_t                 cmd,
    output stat_t                     stat,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [3:0]                action,
    output logic [SEQ_W-1:0]          seq_num,
    output logic [SEQ_W-1:0]          ack_num,
    output logic                      new_packet,
    output logic [SLOT_W-1:0]         slot_index,
    output logic [DUR_W-1:0]          duration,
    output logic [MASK_W-1:0]         slot_mask,
    output logic [SEQ_W-1:0]          run_count,
    output logic                      net_enable,
    output logic                      last
);

    logic [DUR_W-1:0]  dto_reg, ackd_reg, boff_reg;
    logic [2:0]        func_reg;
    logic [1:0]        kind_reg;
    logic              ok_reg;
    logic [SEQ_W-1:0]  fseq_reg, fack_reg;
    logic [MASK_W-1:0] hmask_reg;
    logic [SLOT_W-1:0] tslot_reg;
    logic [SEQ_W-1:0]  nts_reg, old_reg, exp_reg, wend_reg, outs_reg, rseq_reg;
    logic              phy_reg, ridle_reg;
    logic [MASK_W-1:0] arr_reg, nak_reg;
    logic [SEQ_W-1:0]  sseq_reg, cnt_reg, first_reg;
    logic [SLOT_W-1:0] base_reg;
    logic [MASK_W-1:0] rot_reg, mask_reg;
    logic              ov_reg;
    logic [3:0]        act_reg;
    logic [SEQ_W-1:0]  oseq_reg, oack_reg, orun_reg;
    logic              onew_reg, onet_reg, olast_reg;
    logic [SLOT_W-1:0] oslot_reg;
    logic [DUR_W-1:0]  odur_reg;
    logic [MASK_W-1:0] omask_reg;

    logic [SEQ_W-1:0]    miss_seq, target, send_seq, nak_src, ack_span;
    logic                can_send;
    logic [SEQ_W-1:0]    lead_ones;
    logic [MASK_W-1:0]   thermo, gen_mask;
    logic [2*MASK_W-1:0] gen_dbl, rot_dbl;
    logic [3:0]          r_act;
    logic [SEQ_W-1:0]    r_seq, r_ack, r_run;
    logic                r_new, r_net, r_last;
    logic [SLOT_W-1:0]   r_slot;
    logic [DUR_W-1:0]    r_dur;
    logic [MASK_W-1:0]   r_mask;

    // Sequence numbers that the event works on.
    always_comb
    begin
        miss_seq = fack_reg + 7'd1;
        target   = in_window(old_reg, {1'b0, tslot_reg}, nts_reg) ?
                   {1'b0, tslot_reg} : {1'b1, tslot_reg};
        case (func_reg)
            FN_NET_READY: send_seq = nts_reg;
            FN_FRAME_RX:  send_seq = miss_seq;
            default:      send_seq = target;
        endcase
        nak_src  = (!ok_reg) ? fseq_reg : exp_reg;
        can_send = (outs_reg < SEQ_W'(NR_SLOTS));
        ack_span = in_window(old_reg, fack_reg, nts_reg) ? (fack_reg - old_reg + 7'd1) : 7'd0;
    end

    // Count of consecutive arrived slots from the expected one.
    always_comb
    begin
        lead_ones = SEQ_W'(NR_SLOTS);
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (!rot_reg[i])
                lead_ones = SEQ_W'(i);
        end
    end

    // Slot mask of cnt_reg slots starting at base_reg, wrapping around.
    always_comb
    begin
        thermo   = cnt_reg[SEQ_W-1] ? {MASK_W{1'b1}} :
                   ((64'd1 << cnt_reg[SLOT_W-1:0]) - 64'd1);
        gen_dbl  = {thermo, thermo} << base_reg;
        gen_mask = gen_dbl[2*MASK_W-1:MASK_W];
        rot_dbl  = {arr_reg, arr_reg} >> exp_reg[SLOT_W-1:0];
    end

    // Status toward the sequencer.
    always_comb
    begin
        stat.out_free = !ov_reg || out_ready;
        stat.func     = func_reg;
        stat.kind     = kind_reg;
        stat.ok       = ok_reg;
        stat.can_send = can_send;
        stat.miss_in  = in_window(old_reg, miss_seq, nts_reg);
        stat.retx_ok  = ridle_reg || in_window(old_reg, target, rseq_reg + 7'd1);
        stat.nak_cond = (fseq_reg != exp_reg) && nak_reg[exp_reg[SLOT_W-1:0]];
        stat.td_drop  = !in_window(exp_reg, fseq_reg, wend_reg) ||
                        arr_reg[fseq_reg[SLOT_W-1:0]];
        stat.hmask_nz = (hmask_reg != '0);
        stat.cnt_nz   = (cnt_reg != '0);
    end

    // Result builder.
    always_comb
    begin
        r_act  = ACT_STATUS;
        r_seq  = '0;
        r_ack  = '0;
        r_new  = 1'b0;
        r_slot = '0;
        r_dur  = '0;
        r_mask = '0;
        r_run  = '0;
        r_net  = 1'b0;
        r_last = 1'b0;
        case (cmd.res)
            RES_SEND_DATA:
            begin
                r_act = ACT_SEND_DATA;
                r_seq = send_seq;
                r_ack = exp_reg - 7'd1;
                r_new = (func_reg == FN_NET_READY);
            end
            RES_START_DT:
            begin
                r_act  = ACT_START_DT;
                r_slot = sseq_reg[SLOT_W-1:0];
                r_dur  = dto_reg;
            end
            RES_BACKOFF_DT:
            begin
                r_act  = ACT_START_DT;
                r_slot = tslot_reg;
                r_dur  = boff_reg;
            end
            RES_NAK:
            begin
                r_act = ACT_SEND_NAK;
                r_ack = nak_src - 7'd1;
            end
            RES_STOP_ACK:  r_act = ACT_STOP_AT;
            RES_START_ACK:
            begin
                r_act = ACT_START_AT;
                r_dur = ackd_reg;
            end
            RES_DELIVER:
            begin
                r_act = ACT_DELIVER;
                r_seq = first_reg;
                r_run = cnt_reg;
            end
            RES_HMASK:
            begin
                r_act  = ACT_STOP_DT;
                r_mask = hmask_reg;
            end
            RES_STOP_DT:
            begin
                r_act  = ACT_STOP_DT;
                r_mask = mask_reg;
            end
            RES_SEND_ACK:
            begin
                r_act = ACT_SEND_ACK;
                r_seq = nts_reg;
                r_ack = exp_reg - 7'd1;
            end
            default:
            begin
                r_act  = ACT_STATUS;
                r_net  = can_send && phy_reg;
                r_last = 1'b1;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dto_reg  <= DATA_TIMEOUT_RST;
            ackd_reg <= ACK_DELAY_RST;
            boff_reg <= BACKOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DATA_TIMEOUT: dto_reg  <= cfg_data;
                CFG_ACK_DELAY:    ackd_reg <= cfg_data;
                CFG_BACKOFF:      boff_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Event capture and work registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            kind_reg  <= frame_kind;
            ok_reg    <= frame_ok;
            fseq_reg  <= frame_seq;
            fack_reg  <= peer_ack;
            hmask_reg <= half_ack_mask;
            tslot_reg <= timer_slot;
        end
        if (cmd.emit_en && (cmd.res == RES_SEND_DATA))
            sseq_reg <= send_seq;
        if (cmd.rot_en)
            rot_reg <= rot_dbl[MASK_W-1:0];
        if (cmd.run_en)
        begin
            cnt_reg   <= lead_ones;
            base_reg  <= exp_reg[SLOT_W-1:0];
            first_reg <= exp_reg;
        end
        if (cmd.ack_calc)
        begin
            cnt_reg  <= ack_span;
            base_reg <= old_reg[SLOT_W-1:0];
        end
        if (cmd.ack_upd)
            mask_reg <= gen_mask;
    end

    // Link state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nts_reg   <= '0;
            old_reg   <= '0;
            exp_reg   <= '0;
            wend_reg  <= SEQ_W'(NR_SLOTS);
            outs_reg  <= '0;
            phy_reg   <= 1'b0;
            ridle_reg <= 1'b1;
            rseq_reg  <= '0;
            arr_reg   <= '0;
            nak_reg   <= {MASK_W{1'b1}};
        end
        else
        begin
            if (cmd.set_phy)
                phy_reg <= 1'b1;
            if (cmd.emit_en)
            begin
                case (cmd.res)
                    RES_SEND_DATA:
                    begin
                        phy_reg <= 1'b0;
                        if (func_reg == FN_NET_READY)
                        begin
                            outs_reg <= outs_reg + 7'd1;
                            nts_reg  <= nts_reg + 7'd1;
                        end
                        if (func_reg == FN_DATA_TO)
                        begin
                            rseq_reg  <= send_seq;
                            ridle_reg <= 1'b0;
                        end
                    end
                    RES_NAK:
                    begin
                        phy_reg <= 1'b0;
                        nak_reg[nak_src[SLOT_W-1:0]] <= 1'b0;
                    end
                    RES_SEND_ACK: phy_reg <= 1'b0;
                    default:      ;
                endcase
            end
            if (cmd.arrive_set)
                arr_reg[fseq_reg[SLOT_W-1:0]] <= 1'b1;
            if (cmd.clr_en)
            begin
                arr_reg  <= arr_reg & ~gen_mask;
                nak_reg  <= nak_reg | gen_mask;
                exp_reg  <= exp_reg + cnt_reg;
                wend_reg <= wend_reg + cnt_reg;
            end
            // Retire acknowledged frames up to and including peer_ack.
            if (cmd.ack_upd && (cnt_reg != '0))
            begin
                old_reg  <= fack_reg + 7'd1;
                outs_reg <= (outs_reg > cnt_reg) ? (outs_reg - cnt_reg) : 7'd0;
                if (!ridle_reg && ((rseq_reg - old_reg) < cnt_reg))
                    ridle_reg <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit_en)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_en)
        begin
            act_reg   <= r_act;
            oseq_reg  <= r_seq;
            oack_reg  <= r_ack;
            onew_reg  <= r_new;
            oslot_reg <= r_slot;
            odur_reg  <= r_dur;
            omask_reg <= r_mask;
            orun_reg  <= r_run;
            onet_reg  <= r_net;
            olast_reg <= r_last;
        end
    end

    assign out_valid  = ov_reg;
    assign action     = act_reg;
    assign seq_num    = oseq_reg;
    assign ack_num    = oack_reg;
    assign new_packet = onew_reg;
    assign slot_index = oslot_reg;
    assign duration   = odur_reg;
    assign slot_mask  = omask_reg;
    assign run_count  = orun_reg;
    assign net_enable = onet_reg;
    assign last       = olast_reg;

endmodule

`default_nettype wire

// ===== rtl/selective_repeat_arq_controller.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_arq_controller
// Control side of a selective-repeat ARQ link: takes link events and emits
// the ordered send, timer, delivery and status actions they cause.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                       Carries
//  s_axis    in         tvalid tready tdata tuser     one link event
//  m_axis    out        tvalid tready tdata tuser     one action, tlast on status
//                       tlast
//  cfg       in         cfg_we cfg_addr cfg_data      timer durations
//
// An event is captured, then decoded, then sends each result through the
// single output register; it may also check, find and retire an in-order
// run, and retire acknowledged frames.
// A stalled m_axis holds the sequencer in its current result step.
// s_axis_tready is high only while the sequencer is idle.
// Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none

module selective_repeat_arq_controller
    import srarq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // frame_ok, frame_seq, peer_ack, half_ack_mask, timer_slot, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func, frame_kind
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // seq_num, ack_num, new_packet, slot_index, duration, slot_mask,
    // run_count, net_enable, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // action
    output logic [OUT_USER_W-1:0]      m_axis_tuser,
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [DUR_W-1:0]      cfg_data
);

    cmd_t              cmd;
    stat_t             stat;
    logic [SEQ_W-1:0]  seq_num, ack_num, run_count;
    logic              new_packet, net_enable;
    logic [SLOT_W-1:0] slot_index;
    logic [DUR_W-1:0]  duration;
    logic [MASK_W-1:0] slot_mask;

    srarq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srarq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .func          (s_axis_tuser[2:0]),
        .frame_kind    (s_axis_tuser[4:3]),
        .frame_ok      (s_axis_tdata[0]),
        .frame_seq     (s_axis_tdata[7:1]),
        .peer_ack      (s_axis_tdata[14:8]),
        .half_ack_mask (s_axis_tdata[78:15]),
        .timer_slot    (s_axis_tdata[84:79]),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .action        (m_axis_tuser),
        .seq_num       (seq_num),
        .ack_num       (ack_num),
        .new_packet    (new_packet),
        .slot_index    (slot_index),
        .duration      (duration),
        .slot_mask     (slot_mask),
        .run_count     (run_count),
        .net_enable    (net_enable),
        .last          (m_axis_tlast)
    );

    // Pack the result fields, lowest first.
    assign m_axis_tdata = {3'b000, net_enable, run_count, slot_mask, duration,
                           slot_index, new_packet, ack_num, seq_num};

endmodule

`default_nettype wire

// ===== rtl/srarq_checker.sv =====
// ----------------------------------------------------------------------------
// srarq_checker
// Port-level checks of the ARQ controller's request and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

module srarq_checker
    import srarq_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_USER_W-1:0] m_axis_tuser,
    input wire logic                  m_axis_tlast
);

    // A held result stays offered until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // An accepted request closes the input until its results are out.
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted during an event");

    // Only the status result closes an event, and it always does.
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == ACT_STATUS)
        else $error("tlast on a non-status result");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_STATUS |-> m_axis_tlast)
        else $error("status result without tlast");

endmodule

bind selective_repeat_arq_controller srarq_checker u_srarq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
